// ===== src/fp64cc_pkg.sv =====
// Package with shared types, command codes and helpers for the fp64 conversion core.
package fp64cc_pkg;

    typedef enum logic [3:0] {
        CMD_I8   = 4'd0,
        CMD_I16  = 4'd1,
        CMD_I32  = 4'd2,
        CMD_I64  = 4'd3,
        CMD_U8   = 4'd4,
        CMD_U16  = 4'd5,
        CMD_U32  = 4'd6,
        CMD_U64  = 4'd7,
        CMD_F32  = 4'd8,
        CMD_BOOL = 4'd9,
        CMD_COPY = 4'd10,
        CMD_CMP  = 4'd11
    } cmd_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [63:0] value;
        logic [63:0] other_value;
    } in_word_t;

    typedef struct packed {
        logic [63:0] converted_value;
        logic        status;
    } out_word_t;

    // Decoded operand fields shared between the stages.
    typedef struct packed {
        logic        sign;
        logic [10:0] exp;
        logic [51:0] mant;
        logic        is_nan;
        logic        is_zero;
    } fp_fields_t;

    function automatic fp_fields_t unpack_fp(input logic [63:0] b);
        fp_fields_t f;
        f.sign    = b[63];
        f.exp     = b[62:52];
        f.mant    = b[51:0];
        f.is_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        f.is_zero = (b[62:0] == 63'd0);
        return f;
    endfunction

endpackage

// ===== src/fp64cc_pipe.sv =====
// Three-stage conversion datapath: decode and shift, integer/float32 finish, result select.
module fp64cc_pipe
    import fp64cc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  in_word_t  in_word,
    output logic      out_valid,
    output out_word_t out_word
);

    // ---------------- stage 1: decode, shifts, compare ----------------
    fp_fields_t f1;
    fp_fields_t f2;
    logic [52:0]  sig1;
    logic [116:0] wide1;       // significand placed at 2^-53 resolution, integer part 64 bits
    logic         big1;        // magnitude >= 2^64
    logic [1:0]   cmp1;        // 0 eq, 1 gt, 2 lt
    logic [12:0]  fe1;
    logic [6:0]   fsh1;

    always_comb
    begin
        logic signed [12:0] e;
        logic [6:0]         sh;
        f1    = unpack_fp(in_word.value);
        f2    = unpack_fp(in_word.other_value);
        sig1  = {1'b1, f1.mant};
        e     = $signed({2'b00, f1.exp}) - 13'sd1023;
        big1  = (f1.exp >= 11'd1087);
        wide1 = '0;
        sh    = '0;
        if (f1.exp == 11'd0)
        begin
            wide1 = '0;
        end
        else if (!big1)
        begin
            // The leading one of the significand lands at bit 53 + e, since bit 53
            // carries the weight of one. Below 2^-53 only the fraction flag is kept.
            if (e >= -13'sd1)
            begin
                sh    = 7'(e + 13'sd1);
                wide1 = {64'd0, sig1} << sh;
            end
            else if (e >= -13'sd53)
            begin
                sh    = 7'(-(e + 13'sd1));
                wide1 = {64'd0, sig1} >> sh;
            end
        end
        fe1  = 13'({2'b00, f1.exp}) - 13'd896;
        fsh1 = '0;
        if ($signed(fe1) < 13'sd1)
        begin
            if ($signed(13'sd30 - $signed(fe1)) >= 13'sd54)
                fsh1 = 7'd54;
            else
                fsh1 = 7'(13'sd30 - $signed(fe1));
        end
        else
        begin
            fsh1 = 7'd29;
        end
        // IEEE compare on ordered values; a NaN operand gives the lt code
        if (f1.is_nan || f2.is_nan)
            cmp1 = 2'd2;
        else if (f1.is_zero && f2.is_zero)
            cmp1 = 2'd0;
        else if (in_word.value == in_word.other_value)
            cmp1 = 2'd0;
        else if (f1.sign != f2.sign)
            cmp1 = f1.sign ? 2'd2 : 2'd1;
        else if ((in_word.value[62:0] > in_word.other_value[62:0]) ^ f1.sign)
            cmp1 = 2'd1;
        else
            cmp1 = 2'd2;
    end

    logic         v1_reg;
    in_word_t     w1_reg;
    fp_fields_t   f1_reg;
    logic [63:0]  int1_reg;
    logic         frac1_reg;
    logic         big1_reg;
    logic [1:0]   cmp1_reg;
    logic [12:0]  fe1_reg;
    logic [6:0]   fsh1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg    <= in_word;
            f1_reg    <= f1;
            int1_reg  <= wide1[116:53];
            frac1_reg <= (wide1[52:0] != 53'd0) || (f1.exp != 11'd0 && f1.exp < 11'd970);
            big1_reg  <= big1;
            cmp1_reg  <= cmp1;
            fe1_reg   <= fe1;
            fsh1_reg  <= fsh1;
        end
    end

    // ---------------- stage 2: range checks and float32 rounding ----------------
    logic [63:0] ires2;
    logic        ibad2;
    logic [63:0] f32res2;

    always_comb
    begin
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] m;
        logic [63:0] neg;
        logic        sgn;
        mag   = int1_reg;
        sgn   = f1_reg.sign;
        neg   = -mag;
        ibad2 = 1'b0;
        ires2 = '0;
        unique case (w1_reg.command)
            CMD_I8:  ibad2 = sgn ? (mag > 64'd128 || (mag == 64'd128 && frac1_reg))
                                 : (mag > 64'd127 || (mag == 64'd127 && frac1_reg));
            CMD_I16: ibad2 = sgn ? (mag > 64'd32768 || (mag == 64'd32768 && frac1_reg))
                                 : (mag > 64'd32767 || (mag == 64'd32767 && frac1_reg));
            CMD_I32: ibad2 = sgn ? (mag > 64'h8000_0000 || (mag == 64'h8000_0000 && frac1_reg))
                                 : (mag > 64'h7FFF_FFFF || (mag == 64'h7FFF_FFFF && frac1_reg));
            CMD_I64: ibad2 = big1_reg || (sgn ? (mag > 64'h8000_0000_0000_0000)
                                              : (mag[63] == 1'b1));
            CMD_U8:  ibad2 = (mag > 64'd255) || (mag == 64'd255 && frac1_reg);
            CMD_U16: ibad2 = (mag > 64'd65535) || (mag == 64'd65535 && frac1_reg);
            CMD_U32: ibad2 = (mag > 64'hFFFF_FFFF) || (mag == 64'hFFFF_FFFF && frac1_reg);
            CMD_U64: ibad2 = big1_reg;
            default: ibad2 = 1'b0;
        endcase
        if (w1_reg.command <= CMD_I64)
            ires2 = sgn ? neg : mag;
        else
            ires2 = mag;
        // NaN and any magnitude of 2^64 or more, infinity included, are out of range.
        if (f1_reg.is_nan || big1_reg)
            ibad2 = 1'b1;

        // float32 conversion
        m    = {11'd0, 1'b1, f1_reg.mant};
        q    = (fsh1_reg >= 7'd54) ? 64'd0 : (m >> fsh1_reg);
        rem  = m & ((64'd1 << fsh1_reg) - 64'd1);
        half = 64'd1 << (fsh1_reg - 7'd1);
        if (fsh1_reg < 7'd54 && (rem > half || (rem == half && q[0])))
            q = q + 64'd1;
        if (f1_reg.exp == 11'h7FF)
            f32res2 = f1_reg.is_nan
                ? {32'd0, f1_reg.sign, 31'h7FC0_0000 | {9'd0, f1_reg.mant[50:29]}}
                : {32'd0, f1_reg.sign, 31'h7F80_0000};
        else if (f1_reg.exp == 11'd0 || fsh1_reg >= 7'd54)
            f32res2 = {32'd0, f1_reg.sign, 31'd0};
        else if ($signed(fe1_reg) >= 13'sd255)
            f32res2 = {32'd0, f1_reg.sign, 31'h7F80_0000};
        else if ($signed(fe1_reg) >= 13'sd1)
        begin
            if (q == 64'h100_0000)
            begin
                if ($signed(fe1_reg) + 13'sd1 >= 13'sd255)
                    f32res2 = {32'd0, f1_reg.sign, 31'h7F80_0000};
                else
                    f32res2 = {32'd0, f1_reg.sign, 8'(fe1_reg + 13'd1), 23'd0};
            end
            else
                f32res2 = {32'd0, f1_reg.sign, fe1_reg[7:0], q[22:0]};
        end
        else
            f32res2 = {32'd0, f1_reg.sign, q[30:0]};
    end

    logic        v2_reg;
    logic [3:0]  cmd2_reg;
    logic [63:0] vb2_reg;
    logic [63:0] ires2_reg;
    logic        ibad2_reg;
    logic [63:0] f32_2_reg;
    logic [1:0]  cmp2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd2_reg  <= w1_reg.command;
            vb2_reg   <= w1_reg.value;
            ires2_reg <= ires2;
            ibad2_reg <= ibad2;
            f32_2_reg <= f32res2;
            cmp2_reg  <= cmp1_reg;
        end
    end

    // ---------------- stage 3: result select ----------------
    out_word_t res3;

    always_comb
    begin
        res3 = '0;
        case (cmd2_reg) inside
            CMD_I8, CMD_I16, CMD_I32, CMD_I64, CMD_U8, CMD_U16, CMD_U32, CMD_U64:
            begin
                res3.status          = ibad2_reg;
                res3.converted_value = ibad2_reg ? 64'd0 : ires2_reg;
            end
            CMD_F32:  res3.converted_value = f32_2_reg;
            CMD_BOOL: res3.converted_value = {63'd0, vb2_reg[62:0] != 63'd0};
            CMD_COPY: res3.converted_value = vb2_reg;
            CMD_CMP:
            begin
                if (cmp2_reg == 2'd0)
                    res3.converted_value = 64'd0;
                else if (cmp2_reg == 2'd1)
                    res3.converted_value = 64'd1;
                else
                    res3.converted_value = '1;
            end
            default:  res3.status = 1'b1;
        endcase
    end

    logic      v3_reg;
    out_word_t o3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o3_reg <= res3;
    end

    assign out_valid = v3_reg;
    assign out_word  = o3_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v3_reg) && $stable(o3_reg))
        else $error("pipe output changed during stall");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && o3_reg.status |-> o3_reg.converted_value == 64'd0)
        else $error("flagged word carries a nonzero value");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> v2_reg == $past(v1_reg))
        else $error("valid lost in pipe");

endmodule

// ===== src/fp64_convert_and_compare_core.sv =====
// Top level of the fp64 conversion and compare core.
// Every cycle in which the output side is not stalled, this core can take one word:
// a command plus one or two raw IEEE-754 double operands. It returns one result
// word per input word, passed through the three register stages of the datapath
// (decode and alignment shift, range check and float32 rounding, result select).
// A stall on the output side freezes all stages together; the input is still
// ready whenever the output register is empty or being drained, so items flow
// back to back at one word per cycle.
module fp64_convert_and_compare_core
    import fp64cc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    // The whole pipe moves when the last stage is empty or being taken.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    fp64cc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_word   (in_data),
        .out_valid (out_valid),
        .out_word  (out_data)
    );

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped");
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output word changed while stalled");

endmodule
